// ===== rtl/core/dqe_pkg.sv =====
// shared types and constants for the dns query name encoder
`timescale 1ns / 1ps

package dqe_pkg;

    // largest buffer the block can address
    localparam int BUF_MAX  = 512;
    localparam int EFF_CAP  = (BUF_MAX < 512) ? BUF_MAX : 512;
    localparam int HDR_LEN  = 12;
    localparam int LABEL_MAX = 63;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);

    localparam logic [7:0] DOT_CHAR = 8'h2E;
    localparam logic [7:0] END_CHAR = 8'h00;
    localparam logic [7:0] HDR_RD_BYTE = 8'h01;
    localparam logic [7:0] QDCOUNT_LO  = 8'h01;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_LABEL_LONG = 2'd1,
        ST_LABEL_EMPTY = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_QUERY_ID     = 2'd0,
        REG_QUERY_TYPE   = 2'd1,
        REG_QUERY_CLASS  = 2'd2,
        REG_BUFFER_LIMIT = 2'd3
    } reg_idx_t;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_TERM  = 1'b1
    } cmd_kind_t;

    // one queued command from the front to the back
    typedef struct packed {
        cmd_kind_t   kind;
        logic        lw_valid;   // term: label length write comes first
        logic [8:0]  lw_addr;
        logic [7:0]  lw_byte;
        status_t     err;        // term only
        logic [8:0]  tail;       // term only: address of the root label
    } cmd_t;

endpackage

// ===== rtl/core/dns_query_name_encoder.sv =====
// top level of the dns query name encoder
`timescale 1ns / 1ps

// Takes a dotted query name one byte per beat, ended by a zero byte, and
// produces buffer write beats that build a DNS query message: name bytes land
// after their label's length slot, a dot or the terminator writes the length,
// and the terminator adds the root label, type, class and the 12-byte header,
// with the message length on the beat marked is_last (or only an error beat
// with the status). Input bytes are taken one per cycle while the queue has
// room; ordinary bytes and dots give at most one beat each, one per cycle
// through the output register while out_ready holds. A terminator gives 1 to
// 18 beats at that rate while the front takes bytes until the 4-entry queue fills.
// Registers: 0x0 query id, 0x4 record type, 0x8 record class, 0xC buffer_limit.

module dns_query_name_encoder
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  name_char,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        write_valid,
    output logic [8:0]  write_addr,
    output logic [7:0]  write_byte,
    output logic        is_last,
    output logic [1:0]  status,
    output logic [9:0]  message_length
);

    logic [15:0] query_id_reg;
    logic [15:0] rr_type_reg;
    logic [15:0] rr_class_reg;
    logic [9:0]  buffer_limit_reg;

    dqe_pkg::reg_idx_t reg_idx;
    logic              cfg_wr;

    dqe_pkg::cmd_t     q_in;
    dqe_pkg::cmd_t     q_head;
    logic              q_push;
    logic              q_pop;
    logic              q_empty;
    logic              q_full;

    assign pready  = 1'b1;
    assign reg_idx = dqe_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_id_reg     <= 16'd0;
            rr_type_reg      <= 16'd1;
            rr_class_reg     <= 16'd1;
            buffer_limit_reg <= 10'd512;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                dqe_pkg::REG_QUERY_ID:     query_id_reg     <= pwdata[15:0];
                dqe_pkg::REG_QUERY_TYPE:   rr_type_reg      <= pwdata[15:0];
                dqe_pkg::REG_QUERY_CLASS:  rr_class_reg     <= pwdata[15:0];
                dqe_pkg::REG_BUFFER_LIMIT: buffer_limit_reg <= pwdata[9:0];
                default:                   query_id_reg     <= query_id_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            dqe_pkg::REG_QUERY_ID:     prdata = {16'd0, query_id_reg};
            dqe_pkg::REG_QUERY_TYPE:   prdata = {16'd0, rr_type_reg};
            dqe_pkg::REG_QUERY_CLASS:  prdata = {16'd0, rr_class_reg};
            dqe_pkg::REG_BUFFER_LIMIT: prdata = {22'd0, buffer_limit_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    dqe_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .name_char    (name_char),
        .buffer_limit (buffer_limit_reg),
        .q_full       (q_full),
        .push         (q_push),
        .cmd          (q_in)
    );

    dqe_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .pop   (q_pop),
        .dout  (q_head),
        .empty (q_empty),
        .full  (q_full)
    );

    dqe_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (q_head),
        .head_valid     (!q_empty),
        .pop            (q_pop),
        .query_id       (query_id_reg),
        .rr_type        (rr_type_reg),
        .rr_class       (rr_class_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .write_valid    (write_valid),
        .write_addr     (write_addr),
        .write_byte     (write_byte),
        .is_last        (is_last),
        .status         (status),
        .message_length (message_length)
    );

    // a command is only queued when the front had room for it
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    // a good name ends on the last header byte with a length past the tail
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_last && status == dqe_pkg::ST_OK) |->
        (write_valid && write_addr == 9'd11 && message_length >= 10'd17))
        else $error("bad final beat of a good name");

    // error beats carry no write and no length; other beats carry no status
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (!is_last || status != dqe_pkg::ST_OK)) |->
        (message_length == 10'd0 && (is_last || status == dqe_pkg::ST_OK)
         && (!is_last || !write_valid)))
        else $error("status or length on the wrong beat");

endmodule

// ===== rtl/core/dqe_front.sv =====
// front end: accepts name bytes, tracks label state and queues commands
`timescale 1ns / 1ps

module dqe_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         name_char,
    input  logic [9:0]         buffer_limit,
    input  logic               q_full,
    output logic               push,
    output dqe_pkg::cmd_t      cmd
);

    logic [9:0]  label_start_reg, label_start_next;
    logic [6:0]  label_count_reg, label_count_next;
    logic        label_overflowed_reg, label_overflowed_next;
    dqe_pkg::status_t first_error_reg, first_error_next;

    logic [9:0]  lim;
    logic        accept;
    logic        is_dot;
    logic        is_end;
    logic [10:0] byte_addr;
    logic        fe_none;
    dqe_pkg::status_t fe_end;
    dqe_pkg::status_t term_err;
    logic        lw;
    logic [9:0]  ls_end;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign is_dot   = (name_char == dqe_pkg::DOT_CHAR);
    assign is_end   = (name_char == dqe_pkg::END_CHAR);
    assign fe_none  = (first_error_reg == dqe_pkg::ST_OK);

    assign lim = (buffer_limit > 10'(dqe_pkg::EFF_CAP)) ? 10'(dqe_pkg::EFF_CAP)
                                                         : buffer_limit;

    // next free byte of the current label, also the end of the label when closed
    assign byte_addr = 11'(label_start_reg) + 11'd1 + 11'(label_count_reg);

    // closing a label
    always_comb
    begin
        fe_end = first_error_reg;
        lw     = 1'b0;
        ls_end = label_start_reg;
        if (fe_none)
        begin
            if (label_overflowed_reg)
                fe_end = dqe_pkg::ST_LABEL_LONG;
            else if (label_count_reg == 7'd0)
            begin
                if (is_dot)
                    fe_end = dqe_pkg::ST_LABEL_EMPTY;
            end
            else if (byte_addr > 11'(lim))
                fe_end = dqe_pkg::ST_OVERFLOW;
            else
            begin
                lw     = 1'b1;
                ls_end = byte_addr[9:0];
            end
        end
    end

    always_comb
    begin
        if (lim < 10'(dqe_pkg::HDR_LEN))
            term_err = dqe_pkg::ST_OVERFLOW;
        else if (fe_end == dqe_pkg::ST_OK && (11'(ls_end) + 11'd5) > 11'(lim))
            term_err = dqe_pkg::ST_OVERFLOW;
        else
            term_err = fe_end;
    end

    always_comb
    begin
        label_start_next      = label_start_reg;
        label_count_next      = label_count_reg;
        label_overflowed_next = label_overflowed_reg;
        first_error_next      = first_error_reg;
        push                  = 1'b0;
        cmd.kind              = dqe_pkg::CMD_WRITE;
        cmd.lw_valid          = 1'b0;
        cmd.lw_addr           = byte_addr[8:0];
        cmd.lw_byte           = name_char;
        cmd.err               = term_err;
        cmd.tail              = ls_end[8:0];
        if (accept)
        begin
            if (!is_dot && !is_end)
            begin
                push = fe_none && (label_count_reg < 7'(dqe_pkg::LABEL_MAX))
                       && (byte_addr < 11'(lim));
                if (label_count_reg < 7'd64)
                    label_count_next = label_count_reg + 7'd1;
                if (label_count_reg >= 7'(dqe_pkg::LABEL_MAX))
                    label_overflowed_next = 1'b1;
            end
            else
            begin
                cmd.lw_valid = lw;
                cmd.lw_addr  = label_start_reg[8:0];
                cmd.lw_byte  = {1'b0, label_count_reg};
                if (is_dot)
                begin
                    push                  = lw;
                    label_start_next      = ls_end;
                    first_error_next      = fe_end;
                    label_count_next      = 7'd0;
                    label_overflowed_next = 1'b0;
                end
                else
                begin
                    push                  = 1'b1;
                    cmd.kind              = dqe_pkg::CMD_TERM;
                    label_start_next      = 10'(dqe_pkg::HDR_LEN);
                    first_error_next      = dqe_pkg::ST_OK;
                    label_count_next      = 7'd0;
                    label_overflowed_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_start_reg      <= 10'(dqe_pkg::HDR_LEN);
            label_count_reg      <= 7'd0;
            label_overflowed_reg <= 1'b0;
            first_error_reg      <= dqe_pkg::ST_OK;
        end
        else
        begin
            label_start_reg      <= label_start_next;
            label_count_reg      <= label_count_next;
            label_overflowed_reg <= label_overflowed_next;
            first_error_reg      <= first_error_next;
        end
    end

endmodule

// ===== rtl/core/dqe_fifo.sv =====
// short command queue between front and back
`timescale 1ns / 1ps

module dqe_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dqe_pkg::cmd_t     din,
    input  logic              pop,
    output dqe_pkg::cmd_t     dout,
    output logic              empty,
    output logic              full
);

    dqe_pkg::cmd_t                 mem_reg [dqe_pkg::QDEPTH];
    logic [dqe_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [dqe_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [dqe_pkg::QPTR_W:0]      count_reg, count_next;
    logic                          do_push;
    logic                          do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == (dqe_pkg::QPTR_W+1)'(dqe_pkg::QDEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/dqe_back.sv =====
// back end: turns queued commands into buffer write beats
`timescale 1ns / 1ps

module dqe_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  dqe_pkg::cmd_t     head,
    input  logic              head_valid,
    output logic              pop,
    input  logic [15:0]       query_id,
    input  logic [15:0]       rr_type,
    input  logic [15:0]       rr_class,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              write_valid,
    output logic [8:0]        write_addr,
    output logic [7:0]        write_byte,
    output logic              is_last,
    output logic [1:0]        status,
    output logic [9:0]        message_length
);

    logic [4:0]  step_reg, step_next;
    logic        out_valid_reg, out_valid_next;
    logic        wv_reg, wv_next;
    logic [8:0]  wa_reg, wa_next;
    logic [7:0]  wb_reg, wb_next;
    logic        last_reg, last_next;
    logic [1:0]  st_reg, st_next;
    logic [9:0]  len_reg, len_next;

    logic        advance;
    logic [4:0]  step;
    logic        cmd_done;
    logic [3:0]  hdr_idx;

    assign advance = head_valid && (!out_valid_reg || out_ready);
    assign pop     = advance && cmd_done;

    // a term command with no label length write starts at the root label
    assign step = (step_reg == 5'd0 && !head.lw_valid) ? 5'd1 : step_reg;
    assign hdr_idx = 4'(step - 5'd6);

    always_comb
    begin
        wv_next   = 1'b1;
        wa_next   = head.lw_addr;
        wb_next   = head.lw_byte;
        last_next = 1'b0;
        st_next   = dqe_pkg::ST_OK;
        len_next  = 10'd0;
        cmd_done  = 1'b0;
        if (head.kind == dqe_pkg::CMD_WRITE)
            cmd_done = 1'b1;
        else
        begin
            case (step)
                5'd0:
                begin
                    wa_next = head.lw_addr;
                    wb_next = head.lw_byte;
                end
                5'd1:
                begin
                    if (head.err != dqe_pkg::ST_OK)
                    begin
                        wv_next   = 1'b0;
                        wa_next   = 9'd0;
                        wb_next   = 8'd0;
                        last_next = 1'b1;
                        st_next   = head.err;
                        cmd_done  = 1'b1;
                    end
                    else
                    begin
                        wa_next = head.tail;
                        wb_next = 8'd0;
                    end
                end
                5'd2:
                begin
                    wa_next = head.tail + 9'd1;
                    wb_next = rr_type[15:8];
                end
                5'd3:
                begin
                    wa_next = head.tail + 9'd2;
                    wb_next = rr_type[7:0];
                end
                5'd4:
                begin
                    wa_next = head.tail + 9'd3;
                    wb_next = rr_class[15:8];
                end
                5'd5:
                begin
                    wa_next = head.tail + 9'd4;
                    wb_next = rr_class[7:0];
                end
                default:
                begin
                    // header bytes, index 0 to 11
                    wa_next = 9'(hdr_idx);
                    case (hdr_idx)
                        4'd0:    wb_next = query_id[15:8];
                        4'd1:    wb_next = query_id[7:0];
                        4'd2:    wb_next = dqe_pkg::HDR_RD_BYTE;
                        4'd5:    wb_next = dqe_pkg::QDCOUNT_LO;
                        default: wb_next = 8'd0;
                    endcase
                    if (hdr_idx == 4'(dqe_pkg::HDR_LEN - 1))
                    begin
                        last_next = 1'b1;
                        len_next  = 10'(head.tail) + 10'd5;
                        cmd_done  = 1'b1;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (advance)
        begin
            out_valid_next = 1'b1;
            step_next      = cmd_done ? 5'd0 : step + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            wv_reg   <= wv_next;
            wa_reg   <= wa_next;
            wb_reg   <= wb_next;
            last_reg <= last_next;
            st_reg   <= st_next;
            len_reg  <= len_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign write_valid    = wv_reg;
    assign write_addr     = wa_reg;
    assign write_byte     = wb_reg;
    assign is_last        = last_reg;
    assign status         = st_reg;
    assign message_length = len_reg;

endmodule

// ===== tb/dqe_wire_checker.sv =====
// checker for the dns query name encoder: predicts buffer write beats and compares them
`timescale 1ns / 1ps

module dqe_wire_checker
    import dqe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,

    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  name_char,

    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        write_valid,
    input  logic [8:0]  write_addr,
    input  logic [7:0]  write_byte,
    input  logic        is_last,
    input  logic [1:0]  status,
    input  logic [9:0]  message_length,

    output int          mismatch_count,
    output int          pending_beats
);

    typedef struct packed {
        logic        wr_valid;
        logic [8:0]  addr;
        logic [7:0]  data;
        logic        last;
        status_t     st;
        logic [9:0]  msg_len;
    } wire_beat_t;

    wire_beat_t expected_beats[$];

    // register copies
    logic [15:0] qid;
    logic [15:0] qtype;
    logic [15:0] qclass;
    logic [9:0]  buf_limit;

    // per-name encoder state
    logic [9:0]  seg_start;
    logic [6:0]  seg_len;
    logic        seg_too_long;
    status_t     name_error;

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("[%0t] mismatch: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    endtask

    task automatic push_beat(input logic v, input int addr, input int data, input logic last,
                             input status_t st, input int len);
        wire_beat_t b;
        b.wr_valid = v;
        b.addr     = 9'(addr);
        b.data     = 8'(data);
        b.last     = last;
        b.st       = st;
        b.msg_len  = 10'(len);
        expected_beats.push_back(b);
    endtask

    task automatic restart_name();
        seg_start    = 10'(HDR_LEN);
        seg_len      = '0;
        seg_too_long = 1'b0;
        name_error   = ST_OK;
    endtask

    task automatic encode_name_byte(input logic [7:0] ch);
        int lim;
        int addr;
        int p;
        status_t err;
        logic [7:0] hdr [HDR_LEN];
        lim = (int'(buf_limit) > EFF_CAP) ? EFF_CAP : int'(buf_limit);

        if (ch != DOT_CHAR && ch != END_CHAR) begin
            addr = int'(seg_start) + 1 + int'(seg_len);
            if (name_error == ST_OK && seg_len < LABEL_MAX && addr < lim)
                push_beat(1'b1, addr, ch, 1'b0, ST_OK, 0);
            if (seg_len < 64)
                seg_len++;
            if (seg_len > LABEL_MAX)
                seg_too_long = 1'b1;
            return;
        end

        // closing a label: length slot or first error
        if (name_error == ST_OK) begin
            if (seg_too_long)
                name_error = ST_LABEL_LONG;
            else if (seg_len == 0) begin
                if (ch != END_CHAR)
                    name_error = ST_LABEL_EMPTY;
            end
            else if (int'(seg_start) + 1 + int'(seg_len) > lim)
                name_error = ST_OVERFLOW;
            else begin
                push_beat(1'b1, int'(seg_start), int'(seg_len), 1'b0, ST_OK, 0);
                seg_start = seg_start + 10'd1 + 10'(seg_len);
            end
        end

        if (ch == DOT_CHAR) begin
            seg_len      = '0;
            seg_too_long = 1'b0;
            return;
        end

        err = name_error;
        if (lim < HDR_LEN)
            err = ST_OVERFLOW;
        else if (err == ST_OK && int'(seg_start) + 5 > lim)
            err = ST_OVERFLOW;

        if (err != ST_OK)
            push_beat(1'b0, 0, 0, 1'b1, err, 0);
        else begin
            p = int'(seg_start);
            push_beat(1'b1, p,     8'h00,        1'b0, ST_OK, 0);
            push_beat(1'b1, p + 1, qtype[15:8],  1'b0, ST_OK, 0);
            push_beat(1'b1, p + 2, qtype[7:0],   1'b0, ST_OK, 0);
            push_beat(1'b1, p + 3, qclass[15:8], 1'b0, ST_OK, 0);
            push_beat(1'b1, p + 4, qclass[7:0],  1'b0, ST_OK, 0);
            hdr = '{default: 8'h00};
            hdr[0] = qid[15:8];
            hdr[1] = qid[7:0];
            hdr[2] = HDR_RD_BYTE;
            hdr[5] = QDCOUNT_LO;
            for (int i = 0; i < HDR_LEN; i++)
                push_beat(1'b1, i, hdr[i], i == HDR_LEN - 1, ST_OK,
                          (i == HDR_LEN - 1) ? p + 5 : 0);
        end
        restart_name();
    endtask

    function automatic logic [31:0] reg_value(input reg_idx_t idx);
        case (idx)
            REG_QUERY_ID:     return {16'h0, qid};
            REG_QUERY_TYPE:   return {16'h0, qtype};
            REG_QUERY_CLASS:  return {16'h0, qclass};
            REG_BUFFER_LIMIT: return {22'h0, buf_limit};
            default:          return 32'h0;
        endcase
    endfunction

    initial
    begin
        mismatch_count = 0;
        pending_beats  = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        wire_beat_t want;
        if (!rst_n) begin
            qid       = 16'h0;
            qtype     = 16'h1;
            qclass    = 16'h1;
            buf_limit = 10'd512;
            restart_name();
            expected_beats.delete();
        end
        else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (reg_idx_t'(paddr[3:2]))
                        REG_QUERY_ID:     qid       = pwdata[15:0];
                        REG_QUERY_TYPE:   qtype     = pwdata[15:0];
                        REG_QUERY_CLASS:  qclass    = pwdata[15:0];
                        REG_BUFFER_LIMIT: buf_limit = pwdata[9:0];
                        default: ;
                    endcase
                end
                else if (prdata !== reg_value(reg_idx_t'(paddr[3:2])))
                    report_mismatch("register read", prdata, reg_value(reg_idx_t'(paddr[3:2])));
            end

            if (in_valid && in_ready)
                encode_name_byte(name_char);

            if (out_valid && out_ready) begin
                if (expected_beats.size() == 0)
                    report_mismatch("beat with nothing pending, addr", write_addr, 0);
                else begin
                    want = expected_beats.pop_front();
                    if (write_valid !== want.wr_valid)
                        report_mismatch("write_valid", write_valid, want.wr_valid);
                    if (write_addr !== want.addr)
                        report_mismatch("write_addr", write_addr, want.addr);
                    if (write_byte !== want.data)
                        report_mismatch("write_byte", write_byte, want.data);
                    if (is_last !== want.last)
                        report_mismatch("is_last", is_last, want.last);
                    if (status !== want.st)
                        report_mismatch("status", status, want.st);
                    if (message_length !== want.msg_len)
                        report_mismatch("message_length", message_length, want.msg_len);
                end
            end
        end
        pending_beats = expected_beats.size();
    end

endmodule

// ===== tb/testbench.sv =====
// top of the dns query name encoder testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;
    import dqe_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  name_char;
    logic        out_valid;
    logic        out_ready;
    logic        write_valid;
    logic [8:0]  write_addr;
    logic [7:0]  write_byte;
    logic        is_last;
    logic [1:0]  status;
    logic [9:0]  message_length;

    int          mismatch_count;
    int          pending_beats;

    // idling knobs, percent chance of starting a burst
    int          in_gap_pct;
    int          out_stall_pct;
    int          out_stall_left;
    int          bytes_sent;
    int          long_labels_left;
    logic [7:0]  name_bytes[$];

    dns_query_name_encoder i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .name_char      (name_char),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .write_valid    (write_valid),
        .write_addr     (write_addr),
        .write_byte     (write_byte),
        .is_last        (is_last),
        .status         (status),
        .message_length (message_length)
    );

    dqe_wire_checker i_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .name_char      (name_char),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .write_valid    (write_valid),
        .write_addr     (write_addr),
        .write_byte     (write_byte),
        .is_last        (is_last),
        .status         (status),
        .message_length (message_length),
        .mismatch_count (mismatch_count),
        .pending_beats  (pending_beats)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // receiver side drops out_ready in random bursts
    always @(posedge clk)
    begin
        if (out_stall_left > 0)
        begin
            out_stall_left--;
            out_ready <= 1'b0;
        end
        else if (out_stall_pct > 0 && $urandom_range(0, 99) < out_stall_pct)
        begin
            out_stall_left = $urandom_range(0, 6);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send_byte(input logic [7:0] ch);
        int gap;
        if (in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct)
        begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        name_char <= ch;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_name();
        foreach (name_bytes[i])
            send_byte(name_bytes[i]);
    endtask

    // registers change only with the encoder drained
    task automatic wait_idle();
        in_valid <= 1'b0;
        // the checker refreshes its count at each edge, so wait for an edge before looking
        @(posedge clk);
        while (pending_beats != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // write one register, then read it back
    task automatic program_reg(input reg_idx_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 4))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [9:0] pick_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)      return 10'd512;
        else if (r < 70) return 10'($urandom_range(40, 511));
        else if (r < 82) return 10'($urandom_range(17, 39));
        else if (r < 88) return 10'($urandom_range(0, 12));
        else if (r < 94) return 10'd1023;
        else             return 10'($urandom_range(513, 1022));
    endfunction

    // mostly well-formed names, some empty, doubled or trailing dots
    task automatic build_random_name();
        int labels;
        int seg;
        int r;
        logic [7:0] ch;
        name_bytes.delete();
        labels = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
        for (int i = 0; i < labels; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
                seg = 0;
            else if (r < 9 && long_labels_left > 0)
            begin
                seg = $urandom_range(62, 66);
                long_labels_left--;
            end
            else if (r < 20)
                seg = $urandom_range(9, 20);
            else
                seg = $urandom_range(1, 8);
            for (int k = 0; k < seg; k++)
            begin
                do
                    ch = 8'($urandom_range(1, 255));
                while (ch == DOT_CHAR);
                name_bytes.push_back(ch);
            end
            if (i < labels - 1)
                name_bytes.push_back(DOT_CHAR);
        end
        if (labels > 0 && $urandom_range(0, 9) == 0)
            name_bytes.push_back(DOT_CHAR);
        name_bytes.push_back(END_CHAR);
    endtask

    initial
    begin
        #3000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int names_in_phase;
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        in_valid  <= 1'b0;
        name_char <= '0;
        out_ready <= 1'b0;
        in_gap_pct       = 0;
        out_stall_pct    = 0;
        out_stall_left   = 0;
        bytes_sent       = 0;
        long_labels_left = 2;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, dots, empty labels, small buffers
        in_gap_pct    = 20;
        out_stall_pct = 20;
        program_reg(REG_QUERY_ID, 32'h0000_FFFF);
        program_reg(REG_QUERY_TYPE, 32'h0000_0000);
        program_reg(REG_QUERY_CLASS, 32'h0000_FFFF);
        program_reg(REG_BUFFER_LIMIT, 32'd512);
        name_bytes = '{8'hFF, 8'h01, DOT_CHAR, 8'h7F, 8'h80, END_CHAR};
        send_name();
        name_bytes = '{END_CHAR};
        send_name();
        name_bytes = '{8'h61, DOT_CHAR, END_CHAR};
        send_name();
        name_bytes = '{DOT_CHAR, 8'h62, END_CHAR};
        send_name();
        name_bytes = '{8'h61, DOT_CHAR, DOT_CHAR, 8'h62, END_CHAR};
        send_name();
        wait_idle();
        program_reg(REG_QUERY_ID, 32'h0000_0000);
        program_reg(REG_QUERY_TYPE, 32'h0000_FFFF);
        program_reg(REG_QUERY_CLASS, 32'h0000_0000);
        program_reg(REG_BUFFER_LIMIT, 32'd0);
        name_bytes = '{8'h61, END_CHAR};
        send_name();
        wait_idle();
        // tail does not fit after the label
        program_reg(REG_BUFFER_LIMIT, 32'd17);
        name_bytes = '{8'h61, 8'h62, 8'h63, END_CHAR};
        send_name();

        // random phases with their own settings and idling, then plain ones at limit 512
        bytes_sent = 0;
        while (bytes_sent < 260)
        begin
            wait_idle();
            if (bytes_sent >= 215)
            begin
                in_gap_pct    = 0;
                out_stall_pct = 0;
                program_reg(REG_BUFFER_LIMIT, 32'd512);
            end
            else
            begin
                in_gap_pct    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
                out_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
                program_reg(REG_QUERY_ID, {16'h0, pick_word()});
                program_reg(REG_QUERY_TYPE, {16'h0, pick_word()});
                program_reg(REG_QUERY_CLASS, {16'h0, pick_word()});
                program_reg(REG_BUFFER_LIMIT, {22'h0, pick_limit()});
            end
            names_in_phase = $urandom_range(2, 4);
            repeat (names_in_phase)
            begin
                build_random_name();
                send_name();
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_beats != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_beats == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
